// ----- sv/fbc_pkg.sv -----
// Shared constants for the frustum box cull unit.
`default_nettype none

package fbc_pkg;

	// Frustum geometry: six planes, four coefficients each, three axes per box.
	localparam int NUM_PLANES = 6;
	localparam int NUM_COEFFS = 4;
	localparam int NUM_AXES   = 3;
	localparam int NUM_BOX    = 2 * NUM_AXES;

	// Coefficient slot that holds the plane offset.
	localparam int COEF_D = 3;

	// Box slots: minimum corner first, then maximum corner.
	localparam int BOX_MIN = 0;
	localparam int BOX_MAX = NUM_AXES;

	// Request kinds.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEST = 1'b1;

endpackage

`default_nettype wire

// ----- sv/fbc_if.sv -----
// Request and response channel interfaces of the frustum box cull unit.
`default_nettype none

interface fbc_req_if #(
	parameter int MATRIX_WIDTH = 32,
	parameter int COORD_WIDTH  = 24
);
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [1:0]                     column_index;
	logic signed [MATRIX_WIDTH-1:0] col_elem_0;
	logic signed [MATRIX_WIDTH-1:0] col_elem_1;
	logic signed [MATRIX_WIDTH-1:0] col_elem_2;
	logic signed [MATRIX_WIDTH-1:0] col_elem_3;
	logic signed [COORD_WIDTH-1:0]  box_min_x;
	logic signed [COORD_WIDTH-1:0]  box_min_y;
	logic signed [COORD_WIDTH-1:0]  box_min_z;
	logic signed [COORD_WIDTH-1:0]  box_max_x;
	logic signed [COORD_WIDTH-1:0]  box_max_y;
	logic signed [COORD_WIDTH-1:0]  box_max_z;

	modport source (
		output valid, mode, column_index,
		output col_elem_0, col_elem_1, col_elem_2, col_elem_3,
		output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);

	modport sink (
		input  valid, mode, column_index,
		input  col_elem_0, col_elem_1, col_elem_2, col_elem_3,
		input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

interface fbc_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (
		output valid, visible,
		input  ready
	);

	modport sink (
		input  valid, visible,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/fbc_plane_cell.sv -----
// One plane cell: holds one frustum plane and tests the passing box against it.
`default_nettype none

module fbc_plane_cell #(
	parameter int   MATRIX_WIDTH = 32,
	parameter int   COORD_WIDTH  = 24,
	parameter int   ROW_SEL      = 0,
	parameter logic SUBTRACT     = 1'b0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Upstream side of the chain.
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire logic                           in_mode,
	input  wire logic [1:0]                     in_k,
	input  wire logic signed [MATRIX_WIDTH-1:0] in_col [fbc_pkg::NUM_COEFFS],
	input  wire logic signed [COORD_WIDTH-1:0]  in_box [fbc_pkg::NUM_BOX],
	input  wire logic                           in_visible,
	// Downstream side of the chain.
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic                           out_mode,
	output      logic [1:0]                     out_k,
	output      logic signed [MATRIX_WIDTH-1:0] out_col [fbc_pkg::NUM_COEFFS],
	output      logic signed [COORD_WIDTH-1:0]  out_box [fbc_pkg::NUM_BOX],
	output      logic                           out_visible
);

	localparam int COEF_W = MATRIX_WIDTH + 1;
	localparam int PROD_W = COEF_W + COORD_WIDTH;
	localparam int SUM_W  = PROD_W + 2;

	// Plane coefficients a, b, c, d.
	logic signed [COEF_W-1:0] coef_q [fbc_pkg::NUM_COEFFS];

	// Stage 1: request as it entered the cell.
	logic                           valid_s1;
	logic                           mode_s1;
	logic [1:0]                     k_s1;
	logic signed [MATRIX_WIDTH-1:0] col_s1 [fbc_pkg::NUM_COEFFS];
	logic signed [COORD_WIDTH-1:0]  box_s1 [fbc_pkg::NUM_BOX];
	logic                           vis_s1;

	// Stage 2: request plus the three products of the plane test.
	logic                           valid_s2;
	logic                           mode_s2;
	logic [1:0]                     k_s2;
	logic signed [MATRIX_WIDTH-1:0] col_s2 [fbc_pkg::NUM_COEFFS];
	logic signed [COORD_WIDTH-1:0]  box_s2 [fbc_pkg::NUM_BOX];
	logic                           vis_s2;
	logic signed [PROD_W-1:0]       prod_s2 [fbc_pkg::NUM_AXES];
	logic signed [COEF_W-1:0]       d_s2;
	logic                           nz_s2;

	logic                           s2_ready;
	logic signed [COORD_WIDTH-1:0]  corner [fbc_pkg::NUM_AXES];
	logic signed [PROD_W-1:0]       prod_d [fbc_pkg::NUM_AXES];
	logic                           nz_d;
	logic signed [COEF_W-1:0]       coef_new;
	logic signed [SUM_W-1:0]        sum;
	logic                           culled;

	// Each stage takes a new request when it is empty or its holder moves on.
	assign s2_ready = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_ready;

	// New coefficient from a loaded column: row 3 plus or minus the selected row.
	always_comb begin
		if (SUBTRACT) begin
			coef_new = COEF_W'(in_col[fbc_pkg::COEF_D]) - COEF_W'(in_col[ROW_SEL]);
		end else begin
			coef_new = COEF_W'(in_col[fbc_pkg::COEF_D]) + COEF_W'(in_col[ROW_SEL]);
		end
	end

	// Farthest corner along the normal, and its products with the normal.
	always_comb begin
		for (int i = 0; i < fbc_pkg::NUM_AXES; i++) begin
			corner[i] = coef_q[i][COEF_W-1] ? box_s1[fbc_pkg::BOX_MIN + i]
			                                : box_s1[fbc_pkg::BOX_MAX + i];
			prod_d[i] = PROD_W'(coef_q[i]) * PROD_W'(corner[i]);
		end
		nz_d = (|coef_q[0]) || (|coef_q[1]) || (|coef_q[2]);
	end

	// Plane test sum; a zero normal never culls.
	assign sum = SUM_W'(d_s2) + SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1])
	           + SUM_W'(prod_s2[2]);
	assign culled = nz_s2 && sum[SUM_W-1];

	// Control state and plane storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int j = 0; j < fbc_pkg::NUM_COEFFS; j++) begin
				coef_q[j] <= '0;
			end
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			// A load writes the plane as it enters; requests ahead already used the old one.
			if (in_ready && in_valid && in_mode == fbc_pkg::MODE_LOAD) begin
				coef_q[in_k] <= coef_new;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			mode_s1 <= in_mode;
			k_s1    <= in_k;
			col_s1  <= in_col;
			box_s1  <= in_box;
			vis_s1  <= in_visible;
		end
		if (s2_ready) begin
			mode_s2 <= mode_s1;
			k_s2    <= k_s1;
			col_s2  <= col_s1;
			box_s2  <= box_s1;
			vis_s2  <= vis_s1;
			prod_s2 <= prod_d;
			d_s2    <= coef_q[fbc_pkg::COEF_D];
			nz_s2   <= nz_d;
		end
	end

	// Hand the request to the next cell.
	assign out_valid   = valid_s2;
	assign out_mode    = mode_s2;
	assign out_k       = k_s2;
	assign out_col     = col_s2;
	assign out_box     = box_s2;
	assign out_visible = vis_s2 && !culled;

endmodule

`default_nettype wire

// ----- sv/frustum_box_cull_unit.sv -----
// A box test result appears after its request is accepted and has passed
// two register stages in each of the six plane cells; each cell tests one plane.
// Throughput: one request per cycle, loads and tests alike, while responses are taken.
// A column load reaches each plane as it passes, so later tests see the new planes.
// Reset clears all plane coefficients to zero (every box visible) and empties the chain.
// Top level of the frustum box cull unit: a chain of six plane cells.
`default_nettype none

module frustum_box_cull_unit #(
	parameter int MATRIX_WIDTH = 32,
	parameter int COORD_WIDTH  = 24
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fbc_req_if.sink    req,
	fbc_rsp_if.source  rsp
);

	localparam int LINKS = fbc_pkg::NUM_PLANES + 1;

	// Links between cells; link 0 is the request port, the last link the response side.
	logic                           link_valid [LINKS];
	logic                           link_ready [LINKS];
	logic                           link_mode  [LINKS];
	logic [1:0]                     link_k     [LINKS];
	logic signed [MATRIX_WIDTH-1:0] link_col   [LINKS][fbc_pkg::NUM_COEFFS];
	logic signed [COORD_WIDTH-1:0]  link_box   [LINKS][fbc_pkg::NUM_BOX];
	logic                           link_vis   [LINKS];

	// Request port into the head of the chain; a box starts out visible.
	assign link_valid[0] = req.valid;
	assign req.ready     = link_ready[0];
	assign link_mode[0]  = req.mode;
	assign link_k[0]     = req.column_index;
	assign link_col[0][0] = req.col_elem_0;
	assign link_col[0][1] = req.col_elem_1;
	assign link_col[0][2] = req.col_elem_2;
	assign link_col[0][3] = req.col_elem_3;
	assign link_box[0][fbc_pkg::BOX_MIN + 0] = req.box_min_x;
	assign link_box[0][fbc_pkg::BOX_MIN + 1] = req.box_min_y;
	assign link_box[0][fbc_pkg::BOX_MIN + 2] = req.box_min_z;
	assign link_box[0][fbc_pkg::BOX_MAX + 0] = req.box_max_x;
	assign link_box[0][fbc_pkg::BOX_MAX + 1] = req.box_max_y;
	assign link_box[0][fbc_pkg::BOX_MAX + 2] = req.box_max_z;
	assign link_vis[0] = 1'b1;

	// Planes in order left, right, bottom, top, near, far: row 3 plus, then minus, rows 0..2.
	for (genvar p = 0; p < fbc_pkg::NUM_PLANES; p++) begin : g_cell
		localparam int   ROW = p / 2;
		localparam logic SUB = (p % 2) != 0;

		fbc_plane_cell #(
			.MATRIX_WIDTH (MATRIX_WIDTH),
			.COORD_WIDTH  (COORD_WIDTH),
			.ROW_SEL      (ROW),
			.SUBTRACT     (SUB)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_valid    (link_valid[p]),
			.in_ready    (link_ready[p]),
			.in_mode     (link_mode[p]),
			.in_k        (link_k[p]),
			.in_col      (link_col[p]),
			.in_box      (link_box[p]),
			.in_visible  (link_vis[p]),
			.out_valid   (link_valid[p+1]),
			.out_ready   (link_ready[p+1]),
			.out_mode    (link_mode[p+1]),
			.out_k       (link_k[p+1]),
			.out_col     (link_col[p+1]),
			.out_box     (link_box[p+1]),
			.out_visible (link_vis[p+1])
		);
	end

	// Tail of the chain: tests become responses, loads are retired silently.
	assign rsp.valid = link_valid[LINKS-1] && (link_mode[LINKS-1] == fbc_pkg::MODE_TEST);
	assign rsp.visible = link_vis[LINKS-1];
	assign link_ready[LINKS-1] = rsp.ready || (link_mode[LINKS-1] == fbc_pkg::MODE_LOAD);

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench of the frustum box cull unit with a plane predictor and stall patterns.
`timescale 1ns / 100ps

module tb_top;

	localparam int MW = 32;
	localparam int CW = 24;
	localparam int CF = MW + 1;

	// Q16.16 representation of 1.0.
	localparam int Q_ONE = 1 << 16;

	localparam logic signed [MW-1:0] ELEM_MIN = {1'b1, {(MW-1){1'b0}}};
	localparam logic signed [MW-1:0] ELEM_MAX = {1'b0, {(MW-1){1'b1}}};
	localparam int COORD_MIN = -(1 << (CW - 1));
	localparam int COORD_MAX = (1 << (CW - 1)) - 1;

	// Number of requests in the directed part and in the whole run.
	localparam int DIRECTED_ITEMS = 25;
	localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + 600;

	// One request as the sender sees it.
	typedef struct {
		logic                  mode;
		logic [1:0]            column_index;
		logic signed [MW-1:0]  col_elem [fbc_pkg::NUM_COEFFS];
		logic signed [CW-1:0]  box_min [fbc_pkg::NUM_AXES];
		logic signed [CW-1:0]  box_max [fbc_pkg::NUM_AXES];
	} cull_req_t;

	// Keeps its own copy of the frustum planes and the queue of expected verdicts.
	class visibility_tracker;
		logic signed [CF-1:0] coeff [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_COEFFS];
		logic pending_visible [$];
		int mismatches;
		int loads_seen;
		int tests_seen;
		int culled_expected;
		int results_seen;

		function void clear_planes();
			int p;
			int k;
			for (p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
				for (k = 0; k < fbc_pkg::NUM_COEFFS; k++) begin
					coeff[p][k] = '0;
				end
			end
		endfunction

		// Applies an accepted request: a column load updates the planes,
		// a box test queues the predicted verdict.
		function void note_request(cull_req_t r);
			int p;
			int ax;
			logic signed [CF-1:0] row3;
			logic signed [CF-1:0] rowv;
			logic signed [127:0] acc;
			logic signed [CW-1:0] corner;
			logic vis;
			if (r.mode == fbc_pkg::MODE_LOAD) begin
				loads_seen++;
				row3 = CF'(r.col_elem[fbc_pkg::COEF_D]);
				for (ax = 0; ax < fbc_pkg::NUM_AXES; ax++) begin
					rowv = CF'(r.col_elem[ax]);
					coeff[2*ax][r.column_index]   = row3 + rowv;
					coeff[2*ax+1][r.column_index] = row3 - rowv;
				end
				return;
			end
			tests_seen++;
			vis = 1'b1;
			for (p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
				// A plane with no normal never rejects a box.
				if (coeff[p][0] == 0 && coeff[p][1] == 0 && coeff[p][2] == 0)
					continue;
				acc = 128'(coeff[p][fbc_pkg::COEF_D]);
				for (ax = 0; ax < fbc_pkg::NUM_AXES; ax++) begin
					corner = (coeff[p][ax] >= 0) ? r.box_max[ax] : r.box_min[ax];
					acc = acc + 128'(coeff[p][ax]) * 128'(corner);
				end
				if (acc < 0)
					vis = 1'b0;
			end
			if (!vis)
				culled_expected++;
			pending_visible = {pending_visible, vis};
		endfunction

		// Compares one delivered verdict with the oldest prediction.
		function void check_visible(logic got);
			logic want;
			if (pending_visible.size() == 0) begin
				$display("%0t: unexpected verdict: expected none, actual %0b", $time, got);
				mismatches++;
				return;
			end
			want = pending_visible.pop_front();
			results_seen++;
			if (got !== want) begin
				$display("%0t: visible mismatch: expected %0b, actual %0b", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   burst_left;
	int   items_sent;
	bit   long_hold_done;
	visibility_tracker tracker;

	fbc_req_if #(.MATRIX_WIDTH(MW), .COORD_WIDTH(CW)) req_ch ();
	fbc_rsp_if rsp_ch ();

	frustum_box_cull_unit #(
		.MATRIX_WIDTH (MW),
		.COORD_WIDTH  (CW)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// Column load; the box fields carry random junk.
	function automatic cull_req_t make_load(input int k, input logic signed [MW-1:0] e0,
			input logic signed [MW-1:0] e1, input logic signed [MW-1:0] e2,
			input logic signed [MW-1:0] e3);
		cull_req_t r;
		int ax;
		r.mode = fbc_pkg::MODE_LOAD;
		r.column_index = k[1:0];
		r.col_elem[0] = e0;
		r.col_elem[1] = e1;
		r.col_elem[2] = e2;
		r.col_elem[3] = e3;
		for (ax = 0; ax < fbc_pkg::NUM_AXES; ax++) begin
			r.box_min[ax] = CW'($urandom);
			r.box_max[ax] = CW'($urandom);
		end
		return r;
	endfunction

	// Box test; the column fields carry random junk.
	function automatic cull_req_t make_test(input int lx, input int ly, input int lz,
			input int hx, input int hy, input int hz);
		cull_req_t r;
		int k;
		r.mode = fbc_pkg::MODE_TEST;
		r.column_index = 2'($urandom);
		for (k = 0; k < fbc_pkg::NUM_COEFFS; k++)
			r.col_elem[k] = MW'($urandom);
		r.box_min[0] = CW'(lx);
		r.box_min[1] = CW'(ly);
		r.box_min[2] = CW'(lz);
		r.box_max[0] = CW'(hx);
		r.box_max[1] = CW'(hy);
		r.box_max[2] = CW'(hz);
		return r;
	endfunction

	// Any request with every field drawn over its whole range.
	function automatic cull_req_t any_request();
		cull_req_t r;
		int k;
		r.mode = 1'($urandom);
		r.column_index = 2'($urandom);
		for (k = 0; k < fbc_pkg::NUM_COEFFS; k++)
			r.col_elem[k] = MW'($urandom);
		for (k = 0; k < fbc_pkg::NUM_AXES; k++) begin
			r.box_min[k] = CW'($urandom);
			r.box_max[k] = CW'($urandom);
		end
		return r;
	endfunction

	// Offers one request, with a random gap at the start of each burst,
	// and returns at the edge where the request is taken.
	task automatic offer(input cull_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= r.mode;
		req_ch.column_index <= r.column_index;
		req_ch.col_elem_0   <= r.col_elem[0];
		req_ch.col_elem_1   <= r.col_elem[1];
		req_ch.col_elem_2   <= r.col_elem[2];
		req_ch.col_elem_3   <= r.col_elem[3];
		req_ch.box_min_x    <= r.box_min[0];
		req_ch.box_min_y    <= r.box_min[1];
		req_ch.box_min_z    <= r.box_min[2];
		req_ch.box_max_x    <= r.box_max[0];
		req_ch.box_max_y    <= r.box_max[1];
		req_ch.box_max_z    <= r.box_max[2];
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		tracker.note_request(r);
		items_sent++;
	endtask

	// One camera: load a view-projection matrix column by column in random
	// order, then test a stream of boxes around the frustum.
	task automatic run_scene();
		logic signed [MW-1:0] mat [4][4];
		int lo [fbc_pkg::NUM_AXES];
		int hi [fbc_pkg::NUM_AXES];
		int swap;
		int order [4];
		int r;
		int c;
		int j;
		int tmp;
		int w;
		int span;
		int ctr;
		int hs;
		int n_tests;
		int t;
		int pick;
		bit wild;
		wild = ($urandom_range(0, 99) < 15);
		w = $urandom_range(Q_ONE, 1 << 28);
		for (r = 0; r < 4; r++) begin
			for (c = 0; c < 4; c++)
				mat[r][c] = wild ? MW'($urandom) : '0;
		end
		if (!wild) begin
			// Near-orthographic matrix with small skew and perspective terms.
			for (r = 0; r < 3; r++) begin
				for (c = 0; c < 3; c++) begin
					if (r == c)
						mat[r][c] = MW'($urandom_range(Q_ONE / 2, Q_ONE * 2));
					else
						mat[r][c] = MW'(int'($urandom_range(0, 8192)) - 4096);
				end
				if ($urandom_range(0, 3) == 0)
					mat[r][r] = -mat[r][r];
				mat[r][3] = MW'(int'($urandom_range(0, w / 2)) - w / 4);
			end
			for (c = 0; c < 3; c++)
				mat[3][c] = MW'(int'($urandom_range(0, 2048)) - 1024);
			mat[3][3] = MW'(w);
			// Sometimes a pair of planes loses its normal entirely.
			if ($urandom_range(0, 9) == 0) begin
				j = $urandom_range(0, 2);
				for (c = 0; c < 3; c++) begin
					mat[3][c] = '0;
					mat[j][c] = '0;
				end
				if ($urandom_range(0, 1) == 1)
					mat[3][3] = MW'(-w);
			end
		end
		span = (w >> 16) + 2;

		order = '{0, 1, 2, 3};
		for (j = 3; j > 0; j--) begin
			c = $urandom_range(0, j);
			tmp = order[j];
			order[j] = order[c];
			order[c] = tmp;
		end
		for (j = 0; j < 4; j++) begin
			c = order[j];
			offer(make_load(c, mat[0][c], mat[1][c], mat[2][c], mat[3][c]));
		end

		n_tests = $urandom_range(10, 40);
		for (t = 0; t < n_tests && items_sent < TOTAL_ITEMS; t++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// Nudge one column while boxes are in flight.
				c = $urandom_range(0, 3);
				mat[0][c] = MW'(mat[0][c] + int'($urandom_range(0, 512)) - 256);
				mat[3][c] = MW'(mat[3][c] + int'($urandom_range(0, 512)) - 256);
				offer(make_load(c, mat[0][c], mat[1][c], mat[2][c], mat[3][c]));
			end else if (pick < 12) begin
				offer(any_request());
			end else begin
				for (j = 0; j < fbc_pkg::NUM_AXES; j++) begin
					if (wild && pick < 56) begin
						lo[j] = int'($urandom);
						hi[j] = int'($urandom);
					end else begin
						ctr = int'($urandom_range(0, 2 * span)) - span;
						hs = $urandom_range(0, (w >> 17) + 1);
						lo[j] = ctr - hs;
						hi[j] = ctr + hs;
					end
				end
				// A few inverted boxes.
				if ($urandom_range(0, 19) == 0) begin
					j = $urandom_range(0, fbc_pkg::NUM_AXES - 1);
					swap = lo[j];
					lo[j] = hi[j];
					hi[j] = swap;
				end
				offer(make_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
			end
		end
	endtask

	// Receiver: cycles through stall patterns, with one long hold mid-run.
	initial begin
		int cyc;
		int hold;
		cyc = 0;
		hold = 0;
		long_hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!long_hold_done && items_sent >= 300) begin
				hold = 250;
				long_hold_done = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 50) % 4)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= (cyc % 3 != 0);
					2: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// Verdict monitor.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				tracker.check_visible(rsp_ch.visible);
		end
	end

	// Main sequence: reset, directed requests, random scenes, drain.
	initial begin
		tracker = new();
		tracker.clear_planes();
		burst_left = 0;
		items_sent = 0;
		arst_n = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= fbc_pkg::MODE_LOAD;
		req_ch.column_index <= '0;
		req_ch.col_elem_0   <= '0;
		req_ch.col_elem_1   <= '0;
		req_ch.col_elem_2   <= '0;
		req_ch.col_elem_3   <= '0;
		req_ch.box_min_x    <= '0;
		req_ch.box_min_y    <= '0;
		req_ch.box_min_z    <= '0;
		req_ch.box_max_x    <= '0;
		req_ch.box_max_y    <= '0;
		req_ch.box_max_z    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes after reset are all zero, so any box, even inverted, is visible.
		offer(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		offer(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		// Negative offsets with zero normals still never cull.
		offer(make_load(fbc_pkg::COEF_D, 0, 0, 0, -Q_ONE));
		offer(make_test(0, 0, 0, 0, 0, 0));
		// Only the x planes get a normal: a box must reach both x >= 1 and x <= -1.
		offer(make_load(0, Q_ONE, 0, 0, 0));
		offer(make_test(-5, 0, 0, 5, 0, 0));
		offer(make_test(0, 0, 0, 0, 0, 0));
		// Corner exactly on the plane gives a zero sum and stays visible.
		offer(make_test(-1, 0, 0, 1, 0, 0));
		offer(make_test(5, 0, 0, -5, 0, 0));
		// Full unit cube.
		offer(make_load(1, 0, Q_ONE, 0, 0));
		offer(make_load(2, 0, 0, Q_ONE, 0));
		offer(make_test(-1, -1, -1, 1, 1, 1));
		offer(make_test(2, 2, 2, 3, 3, 3));
		offer(make_test(-3, -3, -3, -2, 5, 5));
		// Extreme matrix elements, so the plane sums need the extra bit.
		offer(make_load(0, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN));
		offer(make_load(1, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX));
		offer(make_load(2, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MAX));
		offer(make_load(3, ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MIN));
		offer(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		offer(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		offer(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		offer(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		offer(make_test(0, 0, 0, 0, 0, 0));
		offer(make_load(3, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
		offer(make_test(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));

		while (items_sent < TOTAL_ITEMS)
			run_scene();

		// Drain the verdicts still in the pipeline, then allow late extras to show.
		req_ch.valid <= 1'b0;
		while (tracker.pending_visible.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		$display("Sent %0d requests: %0d column loads and %0d box tests.",
			items_sent, tracker.loads_seen, tracker.tests_seen);
		$display("Checked %0d verdicts, %0d of them culled, with one long output stall.",
			tracker.results_seen, tracker.culled_expected);
		if (tracker.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
